// ----- design/button_debounce_repeat_idle_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce block
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_REPEAT_IDLE_TOP_MACROS_SVH
`define BUTTON_DEBOUNCE_REPEAT_IDLE_TOP_MACROS_SVH

`ifndef SYNTH
`define BDRI_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
`define BDRI_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define BDRI_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define BDRI_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

// ----- design/bdri_pkg.sv -----
// ----------------------------------------------------------------------------
// bdri_pkg
// Shared types and constants of the button debounce, repeat and idle block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdri_pkg;

  localparam int unsigned DEB_W   = 10;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned TMO_W   = 24;
  localparam int unsigned QUIET_W = 17;
  localparam int unsigned IDLE_W  = 25;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 3;

  localparam logic [QUIET_W-1:0] QUIET_MAX = {QUIET_W{1'b1}};
  localparam logic [IDLE_W-1:0]  IDLE_MAX  = {IDLE_W{1'b1}};

  localparam logic [IDX_W-1:0] IDX_DEBOUNCE = 3'd0;
  localparam logic [IDX_W-1:0] IDX_LONG     = 3'd1;
  localparam logic [IDX_W-1:0] IDX_RDELAY   = 3'd2;
  localparam logic [IDX_W-1:0] IDX_RINT     = 3'd3;
  localparam logic [IDX_W-1:0] IDX_IDLE     = 3'd4;

  localparam logic [DEB_W-1:0]  RST_DEBOUNCE = 10'd50;
  localparam logic [HOLD_W-1:0] RST_LONG     = 16'd1000;
  localparam logic [HOLD_W-1:0] RST_RDELAY   = 16'd500;
  localparam logic [HOLD_W-1:0] RST_RINT     = 16'd250;
  localparam logic [TMO_W-1:0]  RST_IDLE     = 24'd30000;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ms;
    logic [HOLD_W-1:0] long_hold_ms;
    logic [HOLD_W-1:0] repeat_delay_ms;
    logic [HOLD_W-1:0] repeat_interval_ms;
    logic [TMO_W-1:0]  idle_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic idle_flag;
    logic repeat_pulse;
    logic long_press_pulse;
    logic press_pulse;
  } result_t;

endpackage

`default_nettype wire

// ----- design/button_debounce_repeat_idle_top.sv -----
// ----------------------------------------------------------------------------
// button_debounce_repeat_idle_top
// Each input beat is one millisecond tick carrying the sampled pin level
// (low means pressed) and produces exactly one result beat with the press,
// long-press and auto-repeat pulses and the idle flag. A beat is accepted
// every clock unless stalled; its result is in the output register on the next
// cycle. The single output register is the only stage, so input is held off
// only while that register is full and out_tready is low. Timings are set
// through five registers on the APB-style port, written while no ticks flow.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_repeat_idle_top_macros.svh"

module button_debounce_repeat_idle_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [7:0]                   in_tdata,   // [0] pin_level
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [7:0]                   out_tdata,  // [0] press_pulse, [1] long_press_pulse,
                                                        // [2] repeat_pulse, [3] idle_flag
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [bdri_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [bdri_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic      [bdri_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);
  import bdri_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    step;

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  bdri_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bdri_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .pin_level (in_tdata[0]),
    .cfg       (cfg),
    .res       (res)
  );

  assign out_valid_nxt = step ? 1'b1 : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r};

  `BDRI_ASSERT(a_hold_blocks_input, clk, rst_n, out_valid_r && !out_tready |-> !in_tready, "input taken over a held result")
  `BDRI_ASSERT(a_step_fills_output, clk, rst_n, step |=> out_valid_r, "accepted beat gave no result")

endmodule

`default_nettype wire

// ----- design/bdri_regs.sv -----
// ----------------------------------------------------------------------------
// bdri_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module bdri_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [bdri_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [bdri_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic      [bdri_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready,
  output bdri_pkg::cfg_t                    cfg
);
  import bdri_pkg::*;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = cfg_paddr[ADDR_W-1:2];
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        IDX_DEBOUNCE: cfg_nxt.debounce_ms        = cfg_pwdata[DEB_W-1:0];
        IDX_LONG:     cfg_nxt.long_hold_ms       = cfg_pwdata[HOLD_W-1:0];
        IDX_RDELAY:   cfg_nxt.repeat_delay_ms    = cfg_pwdata[HOLD_W-1:0];
        IDX_RINT:     cfg_nxt.repeat_interval_ms = cfg_pwdata[HOLD_W-1:0];
        IDX_IDLE:     cfg_nxt.idle_timeout_ms    = cfg_pwdata[TMO_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      IDX_DEBOUNCE: cfg_prdata = {{(DATA_W-DEB_W){1'b0}}, cfg_r.debounce_ms};
      IDX_LONG:     cfg_prdata = {{(DATA_W-HOLD_W){1'b0}}, cfg_r.long_hold_ms};
      IDX_RDELAY:   cfg_prdata = {{(DATA_W-HOLD_W){1'b0}}, cfg_r.repeat_delay_ms};
      IDX_RINT:     cfg_prdata = {{(DATA_W-HOLD_W){1'b0}}, cfg_r.repeat_interval_ms};
      IDX_IDLE:     cfg_prdata = {{(DATA_W-TMO_W){1'b0}}, cfg_r.idle_timeout_ms};
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms        <= RST_DEBOUNCE;
      cfg_r.long_hold_ms       <= RST_LONG;
      cfg_r.repeat_delay_ms    <= RST_RDELAY;
      cfg_r.repeat_interval_ms <= RST_RINT;
      cfg_r.idle_timeout_ms    <= RST_IDLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/bdri_core.sv -----
// ----------------------------------------------------------------------------
// bdri_core
// Per-tick state update: quiet timer, debounce, long press, auto-repeat, idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_repeat_idle_top_macros.svh"

module bdri_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic            pin_level,
  input  wire bdri_pkg::cfg_t  cfg,
  output bdri_pkg::result_t    res
);
  import bdri_pkg::*;

  logic               raw_prev_r, raw_prev_nxt;
  logic               stable_r, stable_nxt;
  logic [QUIET_W-1:0] quiet_r, quiet_nxt;
  logic               long_fired_r, long_fired_nxt;
  logic               rep_armed_r, rep_armed_nxt;
  logic [HOLD_W-1:0]  rep_rem_r, rep_rem_nxt;
  logic [IDLE_W-1:0]  idle_cnt_r, idle_cnt_nxt;
  logic               idle_r, idle_nxt;

  logic               pressed;
  logic               deb_ok;
  logic               press, longp, rep, any;
  logic [IDLE_W-1:0]  idle_inc;

  assign pressed = ~pin_level;

  always_comb begin
    idle_inc = (idle_cnt_r < IDLE_MAX) ? idle_cnt_r + 1'b1 : idle_cnt_r;

    if (pressed != raw_prev_r) begin
      quiet_nxt = '0;
    end else if (quiet_r < QUIET_MAX) begin
      quiet_nxt = quiet_r + 1'b1;
    end else begin
      quiet_nxt = quiet_r;
    end

    deb_ok       = (quiet_nxt > {{(QUIET_W-DEB_W){1'b0}}, cfg.debounce_ms}) &&
                   (pressed != stable_r);
    stable_nxt   = deb_ok ? pressed : stable_r;
    press        = deb_ok & pressed;
    raw_prev_nxt = pressed;

    longp = pressed && !long_fired_r &&
            (quiet_nxt > {{(QUIET_W-HOLD_W){1'b0}}, cfg.long_hold_ms});
    long_fired_nxt = pressed & (long_fired_r | longp);

    rep           = 1'b0;
    rep_armed_nxt = rep_armed_r;
    rep_rem_nxt   = rep_rem_r;
    if (!pressed) begin
      rep_armed_nxt = 1'b0;
      rep_rem_nxt   = '0;
    end else if (!rep_armed_r) begin
      rep_armed_nxt = 1'b1;
      rep_rem_nxt   = cfg.repeat_delay_ms;
    end else if (rep_rem_r <= HOLD_W'(1)) begin
      rep         = 1'b1;
      rep_rem_nxt = cfg.repeat_interval_ms;
    end else begin
      rep_rem_nxt = rep_rem_r - 1'b1;
    end

    any          = press | longp | rep;
    idle_cnt_nxt = any ? '0 : idle_inc;
    idle_nxt     = any ? 1'b0 : idle_r;
    if (idle_cnt_nxt > {{(IDLE_W-TMO_W){1'b0}}, cfg.idle_timeout_ms}) begin
      idle_nxt = 1'b1;
    end

    res.press_pulse      = press;
    res.long_press_pulse = longp;
    res.repeat_pulse     = rep;
    res.idle_flag        = idle_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_prev_r   <= 1'b0;
      stable_r     <= 1'b0;
      quiet_r      <= '0;
      long_fired_r <= 1'b0;
      rep_armed_r  <= 1'b0;
      rep_rem_r    <= '0;
      idle_cnt_r   <= '0;
      idle_r       <= 1'b0;
    end else if (step) begin
      raw_prev_r   <= raw_prev_nxt;
      stable_r     <= stable_nxt;
      quiet_r      <= quiet_nxt;
      long_fired_r <= long_fired_nxt;
      rep_armed_r  <= rep_armed_nxt;
      rep_rem_r    <= rep_rem_nxt;
      idle_cnt_r   <= idle_cnt_nxt;
      idle_r       <= idle_nxt;
    end
  end

  `BDRI_ASSERT(a_press_sets_stable, clk, rst_n, step && res.press_pulse |=> stable_r, "press without stable state")
  `BDRI_ASSERT(a_long_sets_fired, clk, rst_n, step && res.long_press_pulse |=> long_fired_r, "long press not latched")
  `BDRI_ASSERT(a_release_clears, clk, rst_n, step && pin_level |=> !long_fired_r && !rep_armed_r && rep_rem_r == '0, "release left hold state")

endmodule

`default_nettype wire
